// ===== src/sound_voice_allocator_defines.svh =====
// Assertion macros shared by the voice allocator RTL.
`ifndef SOUND_VOICE_ALLOCATOR_DEFINES_SVH
`define SOUND_VOICE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SVA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("voice allocator check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SVA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("voice allocator check failed");

`endif

// ===== src/svalloc_pkg.sv =====
package svalloc_pkg;

    // Channel table size and the widths that follow from it.
    localparam int NUM_CHANNELS = 32;
    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CNT_W        = $clog2(NUM_CHANNELS + 1);

    // Field widths of the command and result transactions.
    localparam int CMD_W     = 2;
    localparam int EMIT_W    = 10;
    localparam int SID_W     = 3;
    localparam int TGT_W     = 5;
    localparam int MODE_W    = 2;
    localparam int TIME_W    = 32;
    localparam int ACT_W     = 6;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;

    // Command codes.
    typedef logic [CMD_W-1:0] t_cmd;
    localparam t_cmd CMD_PICK     = 2'd0;
    localparam t_cmd CMD_PLAY     = 2'd1;
    localparam t_cmd CMD_STOP     = 2'd2;
    localparam t_cmd CMD_FINISHED = 2'd3;

    // Play modes.
    typedef logic [MODE_W-1:0] t_mode;
    localparam t_mode MODE_NORMAL = 2'd0;
    localparam t_mode MODE_LOOPED = 2'd1;
    localparam t_mode MODE_STREAM = 2'd2;

    // Per-channel playback state.
    typedef logic [1:0] t_slot_state;
    localparam t_slot_state ST_FREE   = 2'd0;
    localparam t_slot_state ST_NORMAL = 2'd1;
    localparam t_slot_state ST_LOOPED = 2'd2;
    localparam t_slot_state ST_STREAM = 2'd3;

    // Configuration register indexes.
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ACTIVE_CHANNELS = 1'd0;
    localparam t_cfg_idx CFG_PLAYER_EMITTER  = 1'd1;

    // Owner record kept in the channel memory.
    typedef struct packed {
        logic [EMIT_W-1:0] emitter;
        logic [SID_W-1:0]  id;
        logic [TIME_W-1:0] stamp;
    } t_slot_entry;

endpackage

// ===== src/sound_voice_allocator.sv =====
// Channel      Ports                                       Handshake
// command      start, busy, i_cmd .. i_now_time            taken when start && !busy
// result       o_result_valid, o_granted .. o_freed        one-cycle strobe, no stall
// config       i_cfg_we, i_cfg_index, i_cfg_data           taken when i_cfg_we
//
// A pick scans one channel per cycle through a single read port, over
// min(active_channels, NUM_CHANNELS) channels, or fewer when a free or matching
// channel ends the scan early. Play, stop and finished pass through the op state alone.
// The result strobe is high in the first cycle that busy is low again.
// Reset (synchronous, active low) frees every channel at once; no clearing pass.
// The receiver cannot stall; each result is shown for exactly one cycle.
`include "sound_voice_allocator_defines.svh"

module sound_voice_allocator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [svalloc_pkg::CMD_W-1:0]     i_cmd,
    input  logic [svalloc_pkg::EMIT_W-1:0]    i_emitter,
    input  logic [svalloc_pkg::SID_W-1:0]     i_sound_slot,
    input  logic [svalloc_pkg::TGT_W-1:0]     i_target_channel,
    input  logic [svalloc_pkg::MODE_W-1:0]    i_play_mode,
    input  logic [svalloc_pkg::TIME_W-1:0]    i_now_time,
    input  logic                       i_cfg_we,
    input  logic [svalloc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [svalloc_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                       o_result_valid,
    output logic                       o_granted,
    output logic [svalloc_pkg::TGT_W-1:0]     o_picked_index,
    output logic                       o_overridden,
    output logic                       o_freed
);
    import svalloc_pkg::*;

    // Sequencer states.
    localparam logic [1:0] FSM_IDLE   = 2'd0;
    localparam logic [1:0] FSM_SCAN   = 2'd1;
    localparam logic [1:0] FSM_COMMIT = 2'd2;
    localparam logic [1:0] FSM_OP     = 2'd3;

    logic [1:0]         r_fsm, n_fsm;
    logic [ACT_W-1:0]   r_active_channels;
    logic [EMIT_W-1:0]  r_player_emitter;

    // Captured command transaction.
    t_cmd               r_cmd;
    logic [EMIT_W-1:0]  r_emitter;
    logic [SID_W-1:0]   r_sid;
    logic [TGT_W-1:0]   r_target;
    t_mode              r_mode;
    logic [TIME_W-1:0]  r_now;

    // Channel table: state flags in flip-flops, owner records in a memory.
    logic [NUM_CHANNELS-1:0][1:0] r_slot_state;
    logic [NUM_CHANNELS-1:0]      r_slot_stream;
    logic [NUM_CHANNELS-1:0]      r_slot_valid;
    t_slot_entry                  r_mem [NUM_CHANNELS];

    // Registered read port.
    t_slot_state        r_rd_state;
    logic               r_rd_stream;
    logic               r_rd_valid;
    t_slot_entry        r_rd_entry;

    // Scan pointer and evaluation stage.
    logic [CNT_W-1:0]   r_scan, n_scan;
    logic               r_ev_valid, n_ev_valid;
    logic [CH_W-1:0]    r_ev_idx, n_ev_idx;
    logic [TIME_W-1:0]  r_oldest, n_oldest;
    logic [CH_W-1:0]    r_best_idx, n_best_idx;
    logic               r_found, n_found;
    logic               r_best_over, n_best_over;

    // Result registers.
    logic               r_out_valid, n_out_valid;
    logic               r_granted, n_granted;
    logic [TGT_W-1:0]   r_picked, n_picked;
    logic               r_over, n_over;
    logic               r_freed, n_freed;

    logic [CNT_W-1:0]   live_cnt;
    logic               accept;
    logic [CH_W-1:0]    rd_addr;
    logic [CH_W-1:0]    wr_addr;
    logic               tbl_we;
    t_slot_state        tbl_state;
    logic               tbl_stream;
    logic               mem_we;
    logic               target_live;
    logic [EMIT_W-1:0]  ev_emitter;
    logic [SID_W-1:0]   ev_id;
    logic [TIME_W-1:0]  ev_stamp;
    logic               ev_hit;
    logic               ev_protected;

    assign accept = start && !busy;
    assign busy   = (r_fsm != FSM_IDLE);

    // Channel count used by the scan, saturated at the table size.
    assign live_cnt = (32'(r_active_channels) > 32'(NUM_CHANNELS)) ?
                      CNT_W'(NUM_CHANNELS) : CNT_W'(r_active_channels);
    assign target_live = (32'(r_target) < 32'(live_cnt));

    // One read address: the command's target while idle, the scan pointer otherwise.
    assign rd_addr = (r_fsm == FSM_IDLE) ? CH_W'(i_target_channel) : r_scan[CH_W-1:0];
    assign wr_addr = (r_fsm == FSM_COMMIT) ? r_best_idx : CH_W'(r_target);

    // Entries never written read as zero.
    assign ev_emitter = r_rd_valid ? r_rd_entry.emitter : '0;
    assign ev_id      = r_rd_valid ? r_rd_entry.id      : '0;
    assign ev_stamp   = r_rd_valid ? r_rd_entry.stamp   : '0;

    // A free channel, or one with the same emitter and the same nonzero id, ends the scan unless flagged streaming.
    assign ev_hit = (r_rd_state == ST_FREE) ||
                    ((r_sid != '0) && (ev_emitter == r_emitter) && (ev_id == r_sid));
    assign ev_protected = (r_emitter != r_player_emitter) &&
                          (ev_emitter == r_player_emitter);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_channels <= ACT_W'(32);
            r_player_emitter  <= EMIT_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ACTIVE_CHANNELS: r_active_channels <= i_cfg_data[ACT_W-1:0];
                CFG_PLAYER_EMITTER:  r_player_emitter  <= i_cfg_data[EMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the command transaction.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= i_cmd;
            r_emitter <= i_emitter;
            r_sid     <= i_sound_slot;
            r_target  <= i_target_channel;
            r_mode    <= i_play_mode;
            r_now     <= i_now_time;
        end
    end

    // Sequencer and the shared compare unit.
    always_comb begin
        n_fsm       = r_fsm;
        n_scan      = r_scan;
        n_ev_valid  = 1'b0;
        n_ev_idx    = r_ev_idx;
        n_oldest    = r_oldest;
        n_best_idx  = r_best_idx;
        n_found     = r_found;
        n_best_over = r_best_over;
        n_out_valid = 1'b0;
        n_granted   = r_granted;
        n_picked    = r_picked;
        n_over      = r_over;
        n_freed     = r_freed;
        tbl_we      = 1'b0;
        tbl_state   = ST_FREE;
        tbl_stream  = 1'b0;
        mem_we      = 1'b0;

        case (r_fsm)
            FSM_IDLE: begin
                if (accept) begin
                    if (i_cmd == CMD_PICK) begin
                        n_fsm      = FSM_SCAN;
                        n_scan     = '0;
                        n_oldest   = i_now_time;
                        n_found    = 1'b0;
                        n_best_idx = '0;
                        n_best_over = 1'b0;
                    end else begin
                        n_fsm = FSM_OP;
                    end
                end
            end
            FSM_SCAN: begin
                // Issue the next read while the previous channel is judged.
                if (r_scan < live_cnt) begin
                    n_ev_valid = 1'b1;
                    n_ev_idx   = r_scan[CH_W-1:0];
                    n_scan     = r_scan + CNT_W'(1);
                end
                if (r_ev_valid && !r_rd_stream && ev_hit) begin
                    n_best_idx  = r_ev_idx;
                    n_found     = 1'b1;
                    n_best_over = (r_rd_state != ST_FREE);
                    n_ev_valid  = 1'b0;
                    n_fsm       = FSM_COMMIT;
                end else begin
                    if (r_ev_valid && !r_rd_stream && !ev_protected &&
                        (ev_stamp < r_oldest)) begin
                        n_oldest    = ev_stamp;
                        n_best_idx  = r_ev_idx;
                        n_found     = 1'b1;
                        n_best_over = 1'b1;
                    end
                    if (r_scan >= live_cnt) begin
                        n_fsm = FSM_COMMIT;
                    end
                end
            end
            FSM_COMMIT: begin
                // The taken channel becomes free with the new owner.
                tbl_we      = r_found;
                tbl_state   = ST_FREE;
                tbl_stream  = 1'b0;
                mem_we      = r_found;
                n_out_valid = 1'b1;
                n_granted   = r_found;
                n_picked    = r_found ? TGT_W'(r_best_idx) : '0;
                n_over      = r_found && r_best_over;
                n_freed     = 1'b0;
                n_fsm       = FSM_IDLE;
            end
            FSM_OP: begin
                n_out_valid = 1'b1;
                n_granted   = 1'b0;
                n_picked    = '0;
                n_over      = 1'b0;
                n_freed     = 1'b0;
                n_fsm       = FSM_IDLE;
                if (target_live) begin
                    case (r_cmd)
                        CMD_PLAY: begin
                            case (r_mode)
                                MODE_NORMAL: begin
                                    tbl_we    = 1'b1;
                                    tbl_state = ST_NORMAL;
                                end
                                MODE_LOOPED: begin
                                    tbl_we    = 1'b1;
                                    tbl_state = ST_LOOPED;
                                end
                                MODE_STREAM: begin
                                    tbl_we     = 1'b1;
                                    tbl_state  = ST_STREAM;
                                    tbl_stream = 1'b1;
                                end
                                default: ;
                            endcase
                        end
                        CMD_STOP: begin
                            // Stop keeps the streaming flag.
                            tbl_we     = 1'b1;
                            tbl_state  = ST_FREE;
                            tbl_stream = r_rd_stream;
                            n_freed    = 1'b1;
                        end
                        CMD_FINISHED: begin
                            if (r_rd_state == ST_NORMAL) begin
                                tbl_we     = 1'b1;
                                tbl_state  = ST_FREE;
                                tbl_stream = r_rd_stream;
                                n_freed    = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: begin
                n_fsm = FSM_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= FSM_IDLE;
            r_ev_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_scan      <= '0;
            r_found     <= 1'b0;
        end else begin
            r_fsm       <= n_fsm;
            r_ev_valid  <= n_ev_valid;
            r_out_valid <= n_out_valid;
            r_scan      <= n_scan;
            r_found     <= n_found;
        end
    end

    // Scan payload and result registers.
    always_ff @(posedge i_clk) begin
        r_ev_idx    <= n_ev_idx;
        r_oldest    <= n_oldest;
        r_best_idx  <= n_best_idx;
        r_best_over <= n_best_over;
        r_granted   <= n_granted;
        r_picked    <= n_picked;
        r_over      <= n_over;
        r_freed     <= n_freed;
    end

    // Channel state flags with their registered read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_state  <= '0;
            r_slot_stream <= '0;
            r_slot_valid  <= '0;
        end else begin
            if (tbl_we) begin
                r_slot_state[wr_addr]  <= tbl_state;
                r_slot_stream[wr_addr] <= tbl_stream;
            end
            if (mem_we) begin
                r_slot_valid[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_state  <= r_slot_state[rd_addr];
        r_rd_stream <= r_slot_stream[rd_addr];
        r_rd_valid  <= r_slot_valid[rd_addr];
    end

    // Owner record memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= '{emitter: r_emitter, id: r_sid, stamp: r_now};
        end
        r_rd_entry <= r_mem[rd_addr];
    end

    assign o_result_valid = r_out_valid;
    assign o_granted      = r_granted;
    assign o_picked_index = r_picked;
    assign o_overridden   = r_over;
    assign o_freed        = r_freed;

    // Checks on the sequencer.
    `SVA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy)
    `SVA_ASSERT_NEXT(a_finish_strobe, i_clk, i_rst_n,
        (r_fsm == FSM_COMMIT) || (r_fsm == FSM_OP), o_result_valid && !busy)
    `SVA_ASSERT_IMPLY(a_scan_bound, i_clk, i_rst_n, r_fsm == FSM_SCAN, r_scan <= live_cnt)
    `SVA_ASSERT_IMPLY(a_grant_pick, i_clk, i_rst_n,
        o_result_valid && o_granted, (r_cmd == CMD_PICK) && !o_freed)

endmodule
